### rtl/core/trimmed_mean_sample_filter_defines.svh
// assertion macros for the trimmed mean sample filter checker
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TMSF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the cycle after
`define TMSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tmsf_pkg.sv
// shared constants and types for the trimmed mean sample filter
package tmsf_pkg;

  localparam int SAMPLE_COUNT = 10;
  localparam int TRIM         = 2;
  localparam int EFF_TRIM     = (2 * TRIM >= SAMPLE_COUNT) ? (SAMPLE_COUNT - 1) / 2 : TRIM;
  localparam int KEPT_COUNT   = SAMPLE_COUNT - 2 * EFF_TRIM;
  localparam int SUM_STEPS    = SAMPLE_COUNT - EFF_TRIM;

  localparam int SAMPLE_W     = 12;
  localparam int CNT_W        = $clog2(SAMPLE_COUNT);
  localparam int SUM_W        = SAMPLE_W + $clog2(SAMPLE_COUNT);

  // reciprocal of the kept count; the rounding error times the largest kept sum
  // stays below one unit of the shifted product, so the quotient is exact
  localparam int DIV_SHIFT    = SAMPLE_W + 2 * $clog2(KEPT_COUNT);
  localparam int DIV_MULT     = (2 ** DIV_SHIFT + KEPT_COUNT - 1) / KEPT_COUNT;
  localparam int MULT_W       = DIV_SHIFT + 1;
  localparam int PROD_W       = SUM_W + MULT_W;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SUM,
    ST_DIV
  } fsm_state_t;

  typedef struct packed {
    logic                ins;
    logic                shift;
    logic [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

endpackage

### rtl/core/trimmed_mean_sample_filter.sv
// Samples are taken one per cycle while busy is low; each is sorted into the cell chain at once.
// The request that completes a group raises busy while the chain is shifted out through one
// adder and then while the reciprocal multiply turns the kept sum into the mean.
// done is high for one cycle with the mean, in the last busy cycle; the receiver cannot stall.
// Synchronous reset empties the group and returns to taking samples.
module trimmed_mean_sample_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tmsf_pkg::SAMPLE_W-1:0] sample_mv,
  output logic                          busy,
  output logic                          done,
  output logic [tmsf_pkg::SAMPLE_W-1:0] trimmed_mean_mv
);

  tmsf_pkg::fsm_state_t          state, state_next;
  tmsf_pkg::cell_ctrl_t          ctrl;
  logic [tmsf_pkg::CNT_W-1:0]    count;
  logic [tmsf_pkg::CNT_W-1:0]    k;
  logic [tmsf_pkg::SUM_W-1:0]    acc;
  logic [tmsf_pkg::SUM_W-1:0]    acc_next;
  logic                          group_last;
  logic                          sum_last;
  logic                          div_go;

  logic [tmsf_pkg::SAMPLE_W-1:0] vals [tmsf_pkg::SAMPLE_COUNT];
  logic                          gts  [tmsf_pkg::SAMPLE_COUNT];
  logic                          occ  [tmsf_pkg::SAMPLE_COUNT];

  assign group_last = (count == tmsf_pkg::CNT_W'(tmsf_pkg::SAMPLE_COUNT - 1));
  assign sum_last   = (k == tmsf_pkg::CNT_W'(tmsf_pkg::SUM_STEPS - 1));
  assign div_go     = (state == tmsf_pkg::ST_SUM) && sum_last;

  // head of the chain is the next smallest entry; the lowest ones are skipped
  assign acc_next = (k >= tmsf_pkg::CNT_W'(tmsf_pkg::EFF_TRIM))
                    ? acc + tmsf_pkg::SUM_W'(vals[0]) : acc;

  for (genvar i = 0; i < tmsf_pkg::SAMPLE_COUNT; i++) begin : g_cell
    assign occ[i] = (tmsf_pkg::CNT_W'(i) < count);
    if (i == 0) begin : g_first
      tmsf_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ[i]),
        .left_val  ('0),
        .left_gt   (1'b0),
        .right_val (vals[i+1]),
        .val       (vals[i]),
        .gt        (gts[i])
      );
    end else if (i == tmsf_pkg::SAMPLE_COUNT - 1) begin : g_last
      tmsf_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ[i]),
        .left_val  (vals[i-1]),
        .left_gt   (gts[i-1]),
        .right_val (vals[i]),
        .val       (vals[i]),
        .gt        (gts[i])
      );
    end else begin : g_mid
      tmsf_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ[i]),
        .left_val  (vals[i-1]),
        .left_gt   (gts[i-1]),
        .right_val (vals[i+1]),
        .val       (vals[i]),
        .gt        (gts[i])
      );
    end
  end

  tmsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (acc_next),
    .done     (done),
    .quotient (trimmed_mean_mv)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      tmsf_pkg::ST_FILL: begin
        if (start && group_last) begin
          state_next = tmsf_pkg::ST_SUM;
        end
      end
      tmsf_pkg::ST_SUM: begin
        if (sum_last) begin
          state_next = tmsf_pkg::ST_DIV;
        end
      end
      tmsf_pkg::ST_DIV: begin
        if (done) begin
          state_next = tmsf_pkg::ST_FILL;
        end
      end
      default: state_next = tmsf_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    busy        = (state != tmsf_pkg::ST_FILL);
    ctrl.ins    = (state == tmsf_pkg::ST_FILL) && start;
    ctrl.shift  = (state == tmsf_pkg::ST_SUM);
    ctrl.sample = sample_mv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmsf_pkg::ST_FILL;
      count <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (ctrl.ins) begin
        count <= group_last ? '0 : count + 1'b1;
        k     <= '0;
      end else if (ctrl.shift) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      acc <= '0;
    end else if (ctrl.shift) begin
      acc <= acc_next;
    end
  end

endmodule

### rtl/core/tmsf_cell.sv
// one slot of the sorted insertion chain
module tmsf_cell (
  input  logic                          clk,
  input  tmsf_pkg::cell_ctrl_t          ctrl,
  input  logic                          occupied,
  input  logic [tmsf_pkg::SAMPLE_W-1:0] left_val,
  input  logic                          left_gt,
  input  logic [tmsf_pkg::SAMPLE_W-1:0] right_val,
  output logic [tmsf_pkg::SAMPLE_W-1:0] val,
  output logic                          gt
);

  logic [tmsf_pkg::SAMPLE_W-1:0] val_next;

  assign gt = occupied && (val > ctrl.sample);

  always_comb begin
    val_next = val;
    if (ctrl.ins) begin
      // larger entries move up one slot, new sample lands after equal ones
      if (left_gt) begin
        val_next = left_val;
      end else if (!occupied || gt) begin
        val_next = ctrl.sample;
      end
    end else if (ctrl.shift) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

### rtl/core/tmsf_div.sv
// divider by the kept sample count through a reciprocal multiply, result registered in the cycle after go
module tmsf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [tmsf_pkg::SUM_W-1:0]    dividend,
  output logic                          done,
  output logic [tmsf_pkg::SAMPLE_W-1:0] quotient
);

  logic [tmsf_pkg::MULT_W-1:0] mult;
  logic [tmsf_pkg::PROD_W-1:0] prod;

  assign mult = tmsf_pkg::MULT_W'(tmsf_pkg::DIV_MULT);
  assign prod = tmsf_pkg::PROD_W'(dividend) * tmsf_pkg::PROD_W'(mult);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= prod[tmsf_pkg::DIV_SHIFT +: tmsf_pkg::SAMPLE_W];
    end
  end

endmodule

### rtl/core/tmsf_checker.sv
// port-level checks for the trimmed mean sample filter, bound to the top level
`include "trimmed_mean_sample_filter_defines.svh"

module tmsf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic [tmsf_pkg::SAMPLE_W-1:0] sample_mv,
  input logic                          busy,
  input logic                          done,
  input logic [tmsf_pkg::SAMPLE_W-1:0] trimmed_mean_mv
);

  `TMSF_ASSERT_IMPL(a_done_while_busy, done, busy, "result strobe outside busy window")
  `TMSF_ASSERT_NEXT(a_done_ends_busy, done, !busy && !done, "busy or strobe held after result")
  `TMSF_ASSERT_IMPL(a_busy_after_request, $rose(busy), $past(start && !busy), "busy rose with no request")
  `TMSF_ASSERT_IMPL(a_busy_falls_on_done, $fell(busy), $past(done), "busy fell with no result")

endmodule

bind trimmed_mean_sample_filter tmsf_checker u_tmsf_checker (.*);

### sim/testbench.sv
// self-checking testbench for the trimmed mean sample filter
module testbench;

  class trimmed_mean_tracker;
    logic [tmsf_pkg::SAMPLE_W-1:0] ordered [tmsf_pkg::SAMPLE_COUNT];
    logic [tmsf_pkg::SAMPLE_W-1:0] expected_means [$];
    int filled;
    int trim_used;
    int errors;

    function new();
      filled = 0;
      errors = 0;
      // an oversized trim falls back to keeping at least one sample
      trim_used = (2 * tmsf_pkg::TRIM >= tmsf_pkg::SAMPLE_COUNT)
                  ? (tmsf_pkg::SAMPLE_COUNT - 1) / 2 : tmsf_pkg::TRIM;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // insertion after equal entries, then the mean once the group is full
    function void take_sample(logic [tmsf_pkg::SAMPLE_W-1:0] value);
      int pos;
      int unsigned total;
      pos = filled;
      while (pos > 0 && ordered[pos-1] > value) begin
        ordered[pos] = ordered[pos-1];
        pos--;
      end
      ordered[pos] = value;
      filled++;
      if (filled == tmsf_pkg::SAMPLE_COUNT) begin
        total = 0;
        for (int k = trim_used; k < tmsf_pkg::SAMPLE_COUNT - trim_used; k++) total += ordered[k];
        expected_means.push_back(
          tmsf_pkg::SAMPLE_W'(total / (tmsf_pkg::SAMPLE_COUNT - 2 * trim_used)));
        filled = 0;
      end
    endfunction

    task check_mean(logic [tmsf_pkg::SAMPLE_W-1:0] got);
      logic [tmsf_pkg::SAMPLE_W-1:0] want;
      if (expected_means.size() == 0) begin
        report($sformatf("mean %0d with no group completed", got));
      end else begin
        want = expected_means.pop_front();
        if (got !== want)
          report($sformatf("trimmed_mean_mv %0d, want %0d", got, want));
      end
    endtask

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [tmsf_pkg::SAMPLE_W-1:0] sample_mv = '0;
  logic                          busy;
  logic                          done;
  logic [tmsf_pkg::SAMPLE_W-1:0] trimmed_mean_mv;

  trimmed_mean_tracker tracker;
  bit no_idle;

  trimmed_mean_sample_filter u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .sample_mv       (sample_mv),
    .busy            (busy),
    .done            (done),
    .trimmed_mean_mv (trimmed_mean_mv)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.take_sample(sample_mv);
      if (done) tracker.check_mean(trimmed_mean_mv);
    end
  end

  // start stays high across back-to-back requests
  task send_sample(input logic [tmsf_pkg::SAMPLE_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    sample_mv <= value;
    do @(posedge clk); while (busy);
  endtask

  task send_group(input int kind);
    logic [tmsf_pkg::SAMPLE_W-1:0] base;
    logic [tmsf_pkg::SAMPLE_W-1:0] value;
    base = tmsf_pkg::SAMPLE_W'($urandom_range(0, 4095));
    for (int i = 0; i < tmsf_pkg::SAMPLE_COUNT; i++) begin
      case (kind)
        0: value = tmsf_pkg::SAMPLE_W'($urandom_range(0, 4095));
        // tight cluster, lots of equal samples
        1: value = tmsf_pkg::SAMPLE_W'((base > 4088) ? base - $urandom_range(0, 7)
                                                     : base + $urandom_range(0, 7));
        2: value = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        default: value = base;
      endcase
      send_sample(value);
    end
  endtask

  initial begin
    tracker = new();
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // largest samples give the largest mean
    for (int i = 0; i < tmsf_pkg::SAMPLE_COUNT; i++) send_sample(12'hfff);
    // both extremes, the big ones all fall in the trimmed top end
    for (int i = 0; i < tmsf_pkg::SAMPLE_COUNT; i++) send_sample(i < 2 ? 12'hfff : 12'h000);

    for (int g = 0; g < 65; g++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      send_group($urandom_range(0, 3));
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
